// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros for the change dispenser RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every rising edge outside reset.
`define GCD_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// The expression must never be true outside reset.
`define GCD_ASSERT_NEVER(name, clk, rst_n, expr) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`else

`define GCD_ASSERT(name, clk, rst_n, prop)
`define GCD_ASSERT_NEVER(name, clk, rst_n, expr)

`endif

`endif

// ===== sv/gcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Change dispenser package
// Widths, register map and the word carried along the divider chain.
// ----------------------------------------------------------------------------
package gcd_pkg;

	localparam int DATA_W         = 16;
	localparam int IDX_FIELD_W    = 3;
	localparam int NUM_DENOM_REGS = 6;
	localparam int REG_IDX_W      = 3;

	// Configuration register indexes.
	localparam logic [REG_IDX_W-1:0] REG_NUM_DENOMS = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_DENOM_0    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_DENOM_LAST = 3'd6;

	localparam logic [IDX_FIELD_W-1:0] NUM_DENOMS_RESET = 3'd4;

	typedef logic [DATA_W-1:0] data_t;

	localparam data_t DENOM_RESET [NUM_DENOM_REGS] = '{
		16'd1, 16'd2, 16'd5, 16'd10, 16'd20, 16'd50
	};

	// Mode codes of an input item.
	localparam logic MODE_DISPENSE  = 1'b0;
	localparam logic MODE_SET_STOCK = 1'b1;

	// One division in flight: partial remainder, dividend bits still to be
	// consumed (MSB first), quotient bits so far and the divisor.
	typedef struct packed {
		logic  valid;
		data_t rem;
		data_t dvd;
		data_t quo;
		data_t dsr;
	} div_word_t;

endpackage

// ===== sv/gcd_div_cell.sv =====
// ----------------------------------------------------------------------------
// Divider cell
// One restoring-division step: resolves one quotient bit and hands the
// word on to the next cell.
// ----------------------------------------------------------------------------
module gcd_div_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  gcd_pkg::div_word_t din,
	output gcd_pkg::div_word_t dout
);
	import gcd_pkg::*;

	logic [DATA_W:0] trial;
	logic [DATA_W:0] diff;
	logic            take;

	assign trial = {din.rem, din.dvd[DATA_W-1]};
	assign diff  = trial - {1'b0, din.dsr};
	assign take  = (trial >= {1'b0, din.dsr});

	// Remainder stays below the divisor, so 16 bits hold it after the step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else begin
			dout.valid <= din.valid;
			dout.rem   <= take ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
			dout.dvd   <= {din.dvd[DATA_W-2:0], 1'b0};
			dout.quo   <= {din.quo[DATA_W-2:0], take};
			dout.dsr   <= din.dsr;
		end
	end

endmodule

// ===== sv/greedy_change_dispenser_core.sv =====
// ----------------------------------------------------------------------------
// Greedy change dispenser core
// Pays an amount with a limited stock of up to six coin denominations.
// ----------------------------------------------------------------------------
// Usage:
// An item is transferred when start is high and busy is low. With mode set
// to set-stock, denom_index and stock_value load one stock counter in that
// same cycle and no result follows. With mode set to dispense, the block
// walks the denominations in use from the highest index down to index 0 and
// delivers one result per denomination on coin_index / coin_count, marked by
// a one-cycle strobe; the final result carries last and success.
// Each denomination passes through a launch step, 16 cells of the
// divider chain (one quotient bit per cell), then cap, multiply and update.
// A dispense holds busy for the whole walk, so no new item is taken until
// the walk ends; the results follow one denomination after another.
// The receiver cannot stall: each result is marked by strobe for one cycle only.
// Registers must be written over the APB port only while the block is idle; the block does not enforce this.
// Reset restores the default denominations (1, 2, 5, 10, 20, 50), selects
// four denominations and empties every stock counter.
// ----------------------------------------------------------------------------
module greedy_change_dispenser_core #(
	parameter int MAX_DENOMS = 6
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Item channel
	input  logic                            start,
	output logic                            busy,
	input  logic                            mode,
	input  logic [gcd_pkg::DATA_W-1:0]      amount,
	input  logic [gcd_pkg::IDX_FIELD_W-1:0] denom_index,
	input  logic [gcd_pkg::DATA_W-1:0]      stock_value,
	// Result channel
	output logic                            strobe,
	output logic [gcd_pkg::IDX_FIELD_W-1:0] coin_index,
	output logic [gcd_pkg::DATA_W-1:0]      coin_count,
	output logic                            success,
	output logic                            last,
	// Configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [4:0]                      paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import gcd_pkg::*;

	`include "assert_macros.svh"

	localparam int IDX_W = (MAX_DENOMS > 1) ? $clog2(MAX_DENOMS) : 1;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_LOAD = 6'b000010,
		ST_DIV  = 6'b000100,
		ST_CAP  = 6'b001000,
		ST_PROD = 6'b010000,
		ST_EMIT = 6'b100000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [IDX_FIELD_W-1:0] num_denoms_q;
	data_t                  denom_q [NUM_DENOM_REGS];
	logic [REG_IDX_W-1:0]   reg_idx;
	logic                   cfg_wr;

	// Coin stock, one counter per denomination slot.
	data_t stock_q [MAX_DENOMS];

	// Walk state.
	logic [IDX_FIELD_W-1:0] cur_q;
	data_t                  left_q;
	data_t                  count_q;
	data_t                  prod_q;
	logic [2*DATA_W-1:0]    prod_full;
	logic [IDX_FIELD_W-1:0] active_n;
	data_t                  cur_value;
	data_t                  cur_stock;
	data_t                  left_next;
	data_t                  quotient;
	logic                   can_pay;
	logic                   accept;

	// Result registers.
	logic                   strobe_q;
	logic [IDX_FIELD_W-1:0] coin_index_q;
	data_t                  coin_count_q;
	logic                   success_q;
	logic                   last_q;

	// Divider chain: word k enters cell k, word k+1 leaves it.
	div_word_t chain [DATA_W+1];

	// ------------------------------------------------------------------------
	// Configuration port. Register i sits at byte address 4*i.
	// ------------------------------------------------------------------------
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_denoms_q <= NUM_DENOMS_RESET;
			for (int k = 0; k < NUM_DENOM_REGS; k++) begin
				denom_q[k] <= DENOM_RESET[k];
			end
		end else if (cfg_wr) begin
			if (reg_idx == REG_NUM_DENOMS) begin
				num_denoms_q <= pwdata[IDX_FIELD_W-1:0];
			end else if (reg_idx >= REG_DENOM_0 && reg_idx <= REG_DENOM_LAST) begin
				denom_q[reg_idx - REG_DENOM_0] <= pwdata[DATA_W-1:0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_NUM_DENOMS) begin
			prdata = {{(32-IDX_FIELD_W){1'b0}}, num_denoms_q};
		end else if (reg_idx >= REG_DENOM_0 && reg_idx <= REG_DENOM_LAST) begin
			prdata = {{(32-DATA_W){1'b0}}, denom_q[reg_idx - REG_DENOM_0]};
		end
	end

	// ------------------------------------------------------------------------
	// Walk control. A count of zero denominations behaves as one, and the
	// count is clipped to the number of stock slots that exist.
	// ------------------------------------------------------------------------
	always_comb begin
		if (num_denoms_q == '0) begin
			active_n = IDX_FIELD_W'(1);
		end else if (num_denoms_q > IDX_FIELD_W'(MAX_DENOMS)) begin
			active_n = IDX_FIELD_W'(MAX_DENOMS);
		end else begin
			active_n = num_denoms_q;
		end
	end

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cur_value = denom_q[cur_q];
	assign cur_stock = stock_q[cur_q[IDX_W-1:0]];
	assign quotient  = chain[DATA_W].quo;
	assign left_next = left_q - prod_q;

	// A denomination pays only when something is left, the coin has a value,
	// there is stock and the coin does not exceed what is left.
	assign can_pay = (left_q != '0) && (cur_value != '0) && (cur_stock != '0) &&
		(cur_value <= left_q);

	assign prod_full = count_q * cur_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && mode == MODE_DISPENSE) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (chain[DATA_W].valid) begin
						state_q <= ST_CAP;
					end
				end
				ST_CAP: begin
					state_q <= ST_PROD;
				end
				ST_PROD: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					state_q <= (cur_q == '0) ? ST_IDLE : ST_LOAD;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Walk datapath. The count is capped at the stock; the product can never
	// exceed what is left, so its low half is exact.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cur_q  <= active_n - IDX_FIELD_W'(1);
					left_q <= amount;
				end
			end
			ST_CAP: begin
				if (!can_pay) begin
					count_q <= '0;
				end else if (quotient > cur_stock) begin
					count_q <= cur_stock;
				end else begin
					count_q <= quotient;
				end
			end
			ST_PROD: begin
				prod_q <= prod_full[DATA_W-1:0];
			end
			ST_EMIT: begin
				left_q <= left_next;
				cur_q  <= cur_q - IDX_FIELD_W'(1);
			end
			default: begin
			end
		endcase
	end

	// Stock counters: loaded by a set-stock item, drained on every result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_DENOMS; k++) begin
				stock_q[k] <= '0;
			end
		end else if (state_q == ST_IDLE) begin
			if (accept && mode == MODE_SET_STOCK &&
				denom_index < IDX_FIELD_W'(MAX_DENOMS)) begin
				stock_q[denom_index[IDX_W-1:0]] <= stock_value;
			end
		end else if (state_q == ST_EMIT) begin
			stock_q[cur_q[IDX_W-1:0]] <= cur_stock - count_q;
		end
	end

	// ------------------------------------------------------------------------
	// Divider chain. The launch cycle feeds the remaining amount and the
	// current coin value into the first cell; the quotient leaves the last
	// cell once the word has passed through every cell.
	// ------------------------------------------------------------------------
	always_comb begin
		chain[0].valid = (state_q == ST_LOAD);
		chain[0].rem   = '0;
		chain[0].dvd   = left_q;
		chain[0].quo   = '0;
		chain[0].dsr   = cur_value;
	end

	for (genvar g = 0; g < DATA_W; g++) begin : g_cell
		gcd_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.din    (chain[g]),
			.dout   (chain[g+1])
		);
	end

	// ------------------------------------------------------------------------
	// Result register: one transfer per denomination, highest index first.
	// Success is reported on the final result only.
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (state_q == ST_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT) begin
			coin_index_q <= cur_q;
			coin_count_q <= count_q;
			last_q       <= (cur_q == '0);
			success_q    <= (cur_q == '0) && (left_next == '0);
		end
	end

	assign strobe     = strobe_q;
	assign coin_index = coin_index_q;
	assign coin_count = coin_count_q;
	assign success    = success_q;
	assign last       = last_q;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	// A result that is not the last one leaves the block still working.
	`GCD_ASSERT(a_more_after_partial, clk, arst_n, (strobe_q && !last_q) |-> busy)
	// Success is flagged only together with the final result.
	`GCD_ASSERT_NEVER(a_success_not_last, clk, arst_n, strobe_q && success_q && !last_q)
	// A quotient only leaves the divider chain while the walk waits for it.
	`GCD_ASSERT(a_chain_out_in_div, clk, arst_n, chain[DATA_W].valid |-> (state_q == ST_DIV))
	// The capped count never exceeds the stock it was taken from.
	`GCD_ASSERT(a_count_capped, clk, arst_n, (state_q == ST_CAP) |=> (count_q <= $past(cur_stock)))

endmodule

// ===== tb/sv/dispense_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dispense result checker
// Follows register writes and item transfers on the change dispenser, keeps
// its own copy of the coin values and stock, predicts the coin counts of each
// dispense and compares every result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module dispense_checker #(
	parameter int MAX_DENOMS = 6
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            busy,
	input  logic                            mode,
	input  logic [gcd_pkg::DATA_W-1:0]      amount,
	input  logic [gcd_pkg::IDX_FIELD_W-1:0] denom_index,
	input  logic [gcd_pkg::DATA_W-1:0]      stock_value,
	input  logic                            strobe,
	input  logic [gcd_pkg::IDX_FIELD_W-1:0] coin_index,
	input  logic [gcd_pkg::DATA_W-1:0]      coin_count,
	input  logic                            success,
	input  logic                            last,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic                            pready,
	input  logic [4:0]                      paddr,
	input  logic [31:0]                     pwdata,
	output int                              mismatches,
	output int                              pending
);

	typedef struct packed {
		logic [gcd_pkg::IDX_FIELD_W-1:0] coin_index;
		gcd_pkg::data_t                  coin_count;
		logic                            success;
		logic                            last;
	} payout_t;

	logic [gcd_pkg::IDX_FIELD_W-1:0] denoms_in_use;
	gcd_pkg::data_t                  coin_value [gcd_pkg::NUM_DENOM_REGS];
	gcd_pkg::data_t                  coin_stock [MAX_DENOMS];
	payout_t                         payout_q [$];
	payout_t                         oldest;
	logic [gcd_pkg::REG_IDX_W-1:0]   reg_sel;
	int                              errors = 0;

	// Walks the coins from the highest index in use down to zero, paying the
	// quotient capped at the stock and taking the paid coins out of stock.
	function automatic void predict_payout(input gcd_pkg::data_t amt);
		gcd_pkg::data_t left;
		gcd_pkg::data_t cnt;
		payout_t        p;
		int             n;
		left = amt;
		n = int'(denoms_in_use);
		if (n < 1)
			n = 1;
		if (n > MAX_DENOMS)
			n = MAX_DENOMS;
		if (n > gcd_pkg::NUM_DENOM_REGS)
			n = gcd_pkg::NUM_DENOM_REGS;
		for (int i = n - 1; i >= 0; i--) begin
			cnt = '0;
			if (left != 0 && coin_value[i] != 0 && coin_stock[i] != 0 &&
					coin_value[i] <= left) begin
				cnt = left / coin_value[i];
				if (cnt > coin_stock[i])
					cnt = coin_stock[i];
				left = left - cnt * coin_value[i];
				coin_stock[i] = coin_stock[i] - cnt;
			end
			p.coin_index = 3'(i);
			p.coin_count = cnt;
			p.last       = (i == 0);
			p.success    = (i == 0) && (left == 0);
			payout_q.push_back(p);
		end
	endfunction

	function automatic void check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			denoms_in_use = gcd_pkg::NUM_DENOMS_RESET;
			for (int k = 0; k < gcd_pkg::NUM_DENOM_REGS; k++)
				coin_value[k] = gcd_pkg::DENOM_RESET[k];
			for (int k = 0; k < MAX_DENOMS; k++)
				coin_stock[k] = '0;
			payout_q.delete();
			mismatches <= errors;
			pending    <= 0;
		end else begin
			if (strobe) begin
				if (payout_q.size() == 0) begin
					$error("result transfer with nothing expected: index %0d count %0d",
						coin_index, coin_count);
					errors++;
				end else begin
					oldest = payout_q.pop_front();
					check_field("coin_index", 32'(oldest.coin_index), 32'(coin_index));
					check_field("coin_count", 32'(oldest.coin_count), 32'(coin_count));
					check_field("success", 32'(oldest.success), 32'(success));
					check_field("last", 32'(oldest.last), 32'(last));
				end
			end
			if (psel && penable && pwrite && pready) begin
				reg_sel = paddr[4:2];
				if (reg_sel == gcd_pkg::REG_NUM_DENOMS)
					denoms_in_use = pwdata[gcd_pkg::IDX_FIELD_W-1:0];
				else if (reg_sel >= gcd_pkg::REG_DENOM_0 && reg_sel <= gcd_pkg::REG_DENOM_LAST)
					coin_value[reg_sel - gcd_pkg::REG_DENOM_0] = pwdata[gcd_pkg::DATA_W-1:0];
			end
			if (start && !busy) begin
				if (mode == gcd_pkg::MODE_SET_STOCK) begin
					if (denom_index < MAX_DENOMS)
						coin_stock[denom_index] = stock_value;
				end else begin
					predict_payout(amount);
				end
			end
			mismatches <= errors;
			pending    <= payout_q.size();
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Change dispenser testbench
// Drives set-stock and dispense items and register writes into the greedy
// change dispenser, with random idle bursts, and lets a checker predict and
// compare every result; prints the verdict at the end of the run.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int MAX_DENOMS     = 6;
	// Items per random configuration phase and number of such phases.
	localparam int PHASE_ITEMS    = 40;
	localparam int RANDOM_PHASES  = 8;
	// Cycles let pass once the block is quiet.
	localparam int SETTLE_CYCLES  = 24;
	// Cycles without any transfer before the run is declared hung. The worst
	// correct stretch is a six-coin walk or an idle burst plus the settle time.
	localparam int WATCHDOG_LIMIT = 4000;

	typedef gcd_pkg::data_t coin_set_t [gcd_pkg::NUM_DENOM_REGS];

	logic                            clk;
	logic                            arst_n      = 1'b0;
	logic                            start       = 1'b0;
	logic                            busy;
	logic                            mode        = gcd_pkg::MODE_DISPENSE;
	gcd_pkg::data_t                  amount      = '0;
	logic [gcd_pkg::IDX_FIELD_W-1:0] denom_index = '0;
	gcd_pkg::data_t                  stock_value = '0;
	logic                            strobe;
	logic [gcd_pkg::IDX_FIELD_W-1:0] coin_index;
	gcd_pkg::data_t                  coin_count;
	logic                            success;
	logic                            last;
	logic                            psel        = 1'b0;
	logic                            penable     = 1'b0;
	logic                            pwrite      = 1'b0;
	logic [4:0]                      paddr       = '0;
	logic [31:0]                     pwdata      = '0;
	logic [31:0]                     prdata;
	logic                            pready;

	int mismatches;
	int pending;
	int idle_cycles = 0;
	// When set, the sender inserts random idle bursts after item transfers.
	bit gaps_on     = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	greedy_change_dispenser_core #(
		.MAX_DENOMS(MAX_DENOMS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.amount(amount),
		.denom_index(denom_index),
		.stock_value(stock_value),
		.strobe(strobe),
		.coin_index(coin_index),
		.coin_count(coin_count),
		.success(success),
		.last(last),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	dispense_checker #(
		.MAX_DENOMS(MAX_DENOMS)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.amount(amount),
		.denom_index(denom_index),
		.stock_value(stock_value),
		.strobe(strobe),
		.coin_index(coin_index),
		.coin_count(coin_count),
		.success(success),
		.last(last),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.mismatches(mismatches),
		.pending(pending)
	);

	// Presents one item and holds it until the block takes it, that is until
	// a rising edge sees start high and busy low. The task returns on that
	// edge with start still high, so a following item goes out back to back
	// unless an idle burst is drawn here.
	task automatic send_item(input logic m, input gcd_pkg::data_t amt,
			input logic [gcd_pkg::IDX_FIELD_W-1:0] sel, input gcd_pkg::data_t cnt);
		mode        <= m;
		amount      <= amt;
		denom_index <= sel;
		stock_value <= cnt;
		start       <= 1'b1;
		do @(posedge clk); while (busy);
		if (gaps_on && $urandom_range(0, 2) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	// The fields that the mode does not use carry random values, which the
	// block has to ignore.
	task automatic dispense(input gcd_pkg::data_t amt);
		send_item(gcd_pkg::MODE_DISPENSE, amt, 3'($urandom_range(0, 7)), 16'($urandom));
	endtask

	task automatic set_stock(input logic [gcd_pkg::IDX_FIELD_W-1:0] sel,
			input gcd_pkg::data_t cnt);
		send_item(gcd_pkg::MODE_SET_STOCK, 16'($urandom), sel, cnt);
	endtask

	// Stops sending and waits until every predicted result has been seen and
	// busy is low, then lets the settle time pass so that nothing is still
	// in flight when the registers change.
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0 || busy);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write: a setup phase, then an access phase that completes
	// on the edge where pready is seen high.
	task automatic write_reg(input logic [gcd_pkg::REG_IDX_W-1:0] sel,
			input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Every phase rewrites all seven registers.
	task automatic load_config(input logic [gcd_pkg::IDX_FIELD_W-1:0] n,
			input coin_set_t d);
		write_reg(gcd_pkg::REG_NUM_DENOMS, 32'(n));
		for (int k = 0; k < gcd_pkg::NUM_DENOM_REGS; k++)
			write_reg(3'(gcd_pkg::REG_DENOM_0 + k), 32'(d[k]));
	endtask

	// Mostly an ascending coin set that grows by up to about twice per step,
	// sometimes a fully random one that may hold zero or unordered values.
	// The count in use is now and then outside the valid range.
	task automatic random_config();
		coin_set_t                       d;
		logic [gcd_pkg::IDX_FIELD_W-1:0] n;
		int                              v;
		if ($urandom_range(0, 7) == 0)
			n = 3'($urandom_range(0, 7));
		else
			n = 3'($urandom_range(1, 6));
		v = $urandom_range(1, 5);
		for (int k = 0; k < gcd_pkg::NUM_DENOM_REGS; k++) begin
			d[k] = (v > 65535) ? 16'hFFFF : 16'(v);
			v = v + $urandom_range(1, v + 3);
		end
		if ($urandom_range(0, 4) == 0) begin
			for (int k = 0; k < gcd_pkg::NUM_DENOM_REGS; k++)
				d[k] = 16'($urandom);
		end
		load_config(n, d);
	endtask

	// Random traffic: about a third of the items refill stock, mostly with
	// small counts so that dispenses run the stock dry now and then, and the
	// rest ask for change of assorted sizes. Writes to a stock index past the
	// last counter are ignored by the block and do not count as items.
	task automatic random_phase(input int items);
		int done;
		done = 0;
		while (done < items) begin
			if ($urandom_range(0, 9) < 3) begin
				if ($urandom_range(0, 15) == 0) begin
					set_stock(3'($urandom_range(6, 7)), 16'($urandom));
				end else begin
					if ($urandom_range(0, 7) == 0)
						set_stock(3'($urandom_range(0, 5)), 16'($urandom));
					else
						set_stock(3'($urandom_range(0, 5)), 16'($urandom_range(0, 30)));
					done++;
				end
			end else begin
				case ($urandom_range(0, 3))
					0: dispense(16'($urandom_range(0, 100)));
					1: dispense(16'($urandom_range(0, 1000)));
					2: dispense(16'($urandom));
					default: dispense(16'($urandom_range(0, 300)));
				endcase
				done++;
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		gaps_on = 1'b1;

		// Reset defaults: four coins of 1, 2, 5 and 10, every stock empty.
		// A zero amount succeeds at once; any other amount fails on empty stock.
		dispense(16'd0);
		dispense(16'd7);
		set_stock(3'd0, 16'd3);
		set_stock(3'd1, 16'd2);
		set_stock(3'd2, 16'd1);
		set_stock(3'd3, 16'd4);
		// Counters above the coins in use are still loaded.
		set_stock(3'd4, 16'd5);
		set_stock(3'd5, 16'hFFFF);
		// Indexes past the last counter must be dropped.
		set_stock(3'd6, 16'hAAAA);
		set_stock(3'd7, 16'h5555);
		// Paid in full with coins to spare, then a huge request that drains
		// what stock it can and fails, then a small one against what is left.
		dispense(16'd37);
		dispense(16'hFFFF);
		dispense(16'd1);

		// Wait for the block to go quiet before touching the registers.
		drain();
		// All six coins, the largest at full scale.
		load_config(3'd6, '{16'd1, 16'd3, 16'd7, 16'd250, 16'd4000, 16'hFFFF});
		set_stock(3'd5, 16'd1);
		dispense(16'hFFFF);
		dispense(16'hFFFF);
		dispense(16'd3);

		drain();
		// A count above six acts as six; a zero coin pays nothing and the
		// values need not ascend.
		load_config(3'd7, '{16'd3, 16'd0, 16'd12, 16'd5, 16'hFFFF, 16'd40});
		set_stock(3'd1, 16'd9);
		dispense(16'd100);

		drain();
		// A count of zero acts as one: only coin 0 is used.
		load_config(3'd0, '{16'hFFFF, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1});
		set_stock(3'd0, 16'd2);
		dispense(16'hFFFF);
		dispense(16'hFFFE);

		// Random phases, each under a fresh configuration. Some phases run
		// without idle bursts, and the final one never has any.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain();
			random_config();
			gaps_on = (p < RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
			random_phase(PHASE_ITEMS);
		end

		// Let every result come in and give the block time to show any
		// stray result before the verdict.
		drain();
		if (mismatches == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Hang detection: any item, result or register transfer restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe || (psel && penable && pready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

// ===== greedy_change_dispenser_core.f =====
+incdir+sv
sv/gcd_pkg.sv
sv/gcd_div_cell.sv
sv/greedy_change_dispenser_core.sv
tb/sv/dispense_checker.sv
tb/sv/tb_top.sv
